// ===== rtl/dp2w_pkg.sv =====
`default_nettype none

package dp2w_pkg;

    localparam int DEPTH_W   = 16;
    localparam int RAY_W     = 16;
    localparam int COEF_W    = 16;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int WORLD_W   = 24;
    localparam int COLOR_W   = 8;
    localparam int PROD_W    = DEPTH_W + RAY_W;
    localparam int ROT_FRAC  = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = ROW_W;

    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT_RST = 16'hFFFF;
    localparam logic [ROW_W-1:0]   ROT_X_RST       = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0]   ROT_Y_RST       = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0]   ROT_Z_RST       = 48'h4000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_LIMIT,
        CFG_ROT_X,
        CFG_ROT_Y,
        CFG_ROT_Z,
        CFG_OFF_X,
        CFG_OFF_Y,
        CFG_OFF_Z
    } t_cfg_idx;

    typedef struct packed {
        logic [DEPTH_W-1:0]          depth_limit;
        logic [2:0][ROW_W-1:0]       rot;
        logic [2:0][WORLD_W-1:0]     off;
    } t_cfg;

    typedef struct packed {
        logic               point_valid;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } t_meta;

endpackage

`default_nettype wire

// ===== rtl/dp2w_ifs.sv =====
`default_nettype none

interface dp2w_pixel_if import dp2w_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic        [DEPTH_W-1:0] depth_mm;
    logic signed [RAY_W-1:0]   ray_x;
    logic signed [RAY_W-1:0]   ray_y;
    logic signed [RAY_W-1:0]   ray_z;
    logic        [COLOR_W-1:0] blue_in;
    logic        [COLOR_W-1:0] green_in;
    logic        [COLOR_W-1:0] red_in;

    modport source (output valid, depth_mm, ray_x, ray_y, ray_z, blue_in, green_in, red_in,
                    input ready);
    modport sink   (input valid, depth_mm, ray_x, ray_y, ray_z, blue_in, green_in, red_in,
                    output ready);
endinterface

interface dp2w_point_if import dp2w_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      point_valid;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;
    logic        [COLOR_W-1:0] blue_out;
    logic        [COLOR_W-1:0] green_out;
    logic        [COLOR_W-1:0] red_out;

    modport source (output valid, point_valid, world_x, world_y, world_z,
                    blue_out, green_out, red_out, input ready);
    modport sink   (input valid, point_valid, world_x, world_y, world_z,
                    blue_out, green_out, red_out, output ready);
endinterface

interface dp2w_cfg_if import dp2w_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/depth_pixel_to_world_point.sv =====
`default_nettype none

// channel   dir   handshake          payload
// i_pix     in    valid / ready      depth_mm, ray_x/y/z, blue/green/red_in
// o_pt      out   valid / ready      point_valid, world_x/y/z, blue/green/red_out
// i_cfg     in    valid / ready      index, data (register write, always ready)
//
// one item per cycle sustained while o_pt.ready holds; an accepted item is registered in each stage below in turn
// stages: depth multiply, rotation products, row sums, shift/offset/saturate
// each stage fills a bubble on its own, so stalls on o_pt lose and repeat nothing
// reset clears stage valid bits and loads the identity pose and full far plane

module depth_pixel_to_world_point import dp2w_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    dp2w_pixel_if.sink    i_pix,
    dp2w_point_if.source  o_pt,
    dp2w_cfg_if.sink      i_cfg
);

    localparam int CAM_W = PROD_W - FRAC_BITS;

    t_cfg                     cfg;
    t_meta                    pix_meta;
    t_meta                    cam_meta;
    t_meta                    out_meta;
    logic                     cam_vld;
    logic                     rot_rdy;
    logic [2:0][CAM_W-1:0]    cam;
    logic [2:0][WORLD_W-1:0]  world;

    dp2w_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    assign pix_meta.point_valid = 1'b0;
    assign pix_meta.blue        = i_pix.blue_in;
    assign pix_meta.green       = i_pix.green_in;
    assign pix_meta.red         = i_pix.red_in;

    dp2w_cam_stage #(.FRAC_BITS(FRAC_BITS)) u_cam (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (i_pix.valid),
        .o_rdy         (i_pix.ready),
        .i_depth       (i_pix.depth_mm),
        .i_ray         ({i_pix.ray_z, i_pix.ray_y, i_pix.ray_x}),
        .i_meta        (pix_meta),
        .i_depth_limit (cfg.depth_limit),
        .o_vld         (cam_vld),
        .i_rdy         (rot_rdy),
        .o_cam         (cam),
        .o_meta        (cam_meta)
    );

    dp2w_rotate #(.FRAC_BITS(FRAC_BITS)) u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (cam_vld),
        .o_rdy   (rot_rdy),
        .i_cam   (cam),
        .i_meta  (cam_meta),
        .i_cfg   (cfg),
        .o_vld   (o_pt.valid),
        .i_rdy   (o_pt.ready),
        .o_world (world),
        .o_meta  (out_meta)
    );

    assign o_pt.point_valid = out_meta.point_valid;
    assign o_pt.world_x     = world[0];
    assign o_pt.world_y     = world[1];
    assign o_pt.world_z     = world[2];
    assign o_pt.blue_out    = out_meta.blue;
    assign o_pt.green_out   = out_meta.green;
    assign o_pt.red_out     = out_meta.red;

endmodule

`default_nettype wire

// ===== rtl/dp2w_cfg_regs.sv =====
`default_nettype none

module dp2w_cfg_regs import dp2w_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [CFG_DAT_W-1:0] i_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (i_index)
                CFG_DEPTH_LIMIT: n_cfg.depth_limit = i_data[DEPTH_W-1:0];
                CFG_ROT_X:       n_cfg.rot[0]      = i_data[ROW_W-1:0];
                CFG_ROT_Y:       n_cfg.rot[1]      = i_data[ROW_W-1:0];
                CFG_ROT_Z:       n_cfg.rot[2]      = i_data[ROW_W-1:0];
                CFG_OFF_X:       n_cfg.off[0]      = i_data[WORLD_W-1:0];
                CFG_OFF_Y:       n_cfg.off[1]      = i_data[WORLD_W-1:0];
                CFG_OFF_Z:       n_cfg.off[2]      = i_data[WORLD_W-1:0];
                default:         n_cfg             = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.depth_limit <= DEPTH_LIMIT_RST;
            r_cfg.rot[0]      <= ROT_X_RST;
            r_cfg.rot[1]      <= ROT_Y_RST;
            r_cfg.rot[2]      <= ROT_Z_RST;
            r_cfg.off         <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    a_far_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_index == CFG_DEPTH_LIMIT)
        |=> (r_cfg.depth_limit == $past(i_data[DEPTH_W-1:0])))
        else $error("far plane write lost");

endmodule

`default_nettype wire

// ===== rtl/dp2w_cam_stage.sv =====
`default_nettype none

module dp2w_cam_stage import dp2w_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    output logic                              o_rdy,
    input  wire logic [DEPTH_W-1:0]           i_depth,
    input  wire logic [2:0][RAY_W-1:0]        i_ray,
    input  wire t_meta                        i_meta,
    input  wire logic [DEPTH_W-1:0]           i_depth_limit,
    output logic                              o_vld,
    input  wire logic                         i_rdy,
    output logic [2:0][PROD_W-FRAC_BITS-1:0]  o_cam,
    output t_meta                             o_meta
);

    logic                    r_a_vld;
    logic [2:0][PROD_W-1:0]  r_a_prod;
    t_meta                   r_a_meta;
    logic [2:0][PROD_W-1:0]  n_a_prod;
    t_meta                   n_a_meta;
    logic                    ld_a;

    assign ld_a  = !r_a_vld || i_rdy;
    assign o_rdy = ld_a;
    assign o_vld = r_a_vld;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_a_prod[k] = PROD_W'($signed(i_ray[k]) * $signed({1'b0, i_depth}));
        end
        n_a_meta             = i_meta;
        n_a_meta.point_valid = (i_depth != '0) && (i_depth < i_depth_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (ld_a) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_a && i_vld) begin
            r_a_prod <= n_a_prod;
            r_a_meta <= n_a_meta;
        end
    end

    // floor shift is a plain arithmetic drop of the fraction bits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            o_cam[k] = r_a_prod[k][PROD_W-1:FRAC_BITS];
        end
    end
    assign o_meta = r_a_meta;

    a_zero_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_vld && ld_a && i_depth == '0)
        |=> (r_a_prod == '0 && !r_a_meta.point_valid))
        else $error("zero depth item not flagged or not at origin");

endmodule

`default_nettype wire

// ===== rtl/dp2w_rotate.sv =====
`default_nettype none

module dp2w_rotate import dp2w_pkg::*; #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_vld,
    output logic                              o_rdy,
    input  wire logic [2:0][PROD_W-FRAC_BITS-1:0] i_cam,
    input  wire t_meta                        i_meta,
    input  wire t_cfg                         i_cfg,
    output logic                              o_vld,
    input  wire logic                         i_rdy,
    output logic [2:0][WORLD_W-1:0]           o_world,
    output t_meta                             o_meta
);

    localparam int CAM_W = PROD_W - FRAC_BITS;
    localparam int BP_W  = COEF_W + CAM_W;
    localparam int ACC_W = BP_W + 2;
    localparam int SHF_W = ACC_W - ROT_FRAC;
    localparam int SUM_W = ((SHF_W > WORLD_W) ? SHF_W : WORLD_W) + 1;

    logic                        r_vb, r_vc, r_vd;
    logic                        ld_b, ld_c, ld_d;
    logic [2:0][2:0][BP_W-1:0]   r_b_prod;
    logic [2:0][2:0][BP_W-1:0]   n_b_prod;
    t_meta                       r_b_meta;
    logic [2:0][ACC_W-1:0]       r_c_sum;
    logic [2:0][ACC_W-1:0]       n_c_sum;
    t_meta                       r_c_meta;
    logic [2:0][WORLD_W-1:0]     r_d_world;
    logic [2:0][WORLD_W-1:0]     n_d_world;
    t_meta                       r_d_meta;
    logic signed [SUM_W-1:0]     d_total [3];

    assign ld_d  = !r_vd || i_rdy;
    assign ld_c  = !r_vc || ld_d;
    assign ld_b  = !r_vb || ld_c;
    assign o_rdy = ld_b;

    // stage b: nine coefficient products
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                n_b_prod[r][k] = BP_W'($signed(i_cfg.rot[r][k*COEF_W +: COEF_W])
                                       * $signed(i_cam[k]));
            end
        end
    end

    // stage c: row sums
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_c_sum[r] = ACC_W'($signed(r_b_prod[r][0])) + ACC_W'($signed(r_b_prod[r][1]))
                       + ACC_W'($signed(r_b_prod[r][2]));
        end
    end

    // stage d: floor shift, translation, saturation
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            d_total[r] = SUM_W'($signed(r_c_sum[r][ACC_W-1:ROT_FRAC]))
                       + SUM_W'($signed(i_cfg.off[r]));
            if (d_total[r][SUM_W-1:WORLD_W-1] == {(SUM_W-WORLD_W+1){d_total[r][SUM_W-1]}}) begin
                n_d_world[r] = d_total[r][WORLD_W-1:0];
            end else if (d_total[r][SUM_W-1]) begin
                n_d_world[r] = {1'b1, {(WORLD_W-1){1'b0}}};
            end else begin
                n_d_world[r] = {1'b0, {(WORLD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            if (ld_b) begin
                r_vb <= i_vld;
            end
            if (ld_c) begin
                r_vc <= r_vb;
            end
            if (ld_d) begin
                r_vd <= r_vc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_b && i_vld) begin
            r_b_prod <= n_b_prod;
            r_b_meta <= i_meta;
        end
        if (ld_c && r_vb) begin
            r_c_sum  <= n_c_sum;
            r_c_meta <= r_b_meta;
        end
        if (ld_d && r_vc) begin
            r_d_world <= n_d_world;
            r_d_meta  <= r_c_meta;
        end
    end

    assign o_vld   = r_vd;
    assign o_world = r_d_world;
    assign o_meta  = r_d_meta;

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vb && r_vc && r_vd && !i_rdy) |-> !o_rdy)
        else $error("full pipe accepts while stalled");

    a_c_to_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vc && ld_d) |=> r_vd)
        else $error("item lost between sum and output stage");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vd && !i_rdy) |=> (r_vd && $stable(r_d_world)))
        else $error("output item changed while stalled");

endmodule

`default_nettype wire
